### rtl/utf8_stream_decoder_defines.svh
// Assertion macros shared by the UTF-8 stream decoder RTL.
// Expects clk_i and rst_ni in the scope of every use.
`ifndef UTF8_STREAM_DECODER_DEFINES_SVH
`define UTF8_STREAM_DECODER_DEFINES_SVH

// Property that must hold at every clock edge outside reset.
`define UTF8SD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Implication checked in the cycle after the antecedent.
`define UTF8SD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/utf8sd_pkg.sv
// Types, constants and decode functions of the UTF-8 stream decoder.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package utf8sd_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       string_end;
  } beat_t;

  typedef struct packed {
    logic [23:0] char_val;
    logic        has_char;
    logic        end_of_text;
  } result_t;

  // Lead byte patterns
  localparam logic [7:0] LeadAsciiMask = 8'b1000_0000;
  localparam logic [7:0] Lead2Mask     = 8'b1110_0000;
  localparam logic [7:0] Lead2Val      = 8'b1100_0000;
  localparam logic [7:0] Lead3Mask     = 8'b1111_0000;
  localparam logic [7:0] Lead3Val      = 8'b1110_0000;
  localparam logic [7:0] Lead4Mask     = 8'b1111_1000;
  localparam logic [7:0] Lead4Val      = 8'b1111_0000;

  // Packed word patterns, oldest byte highest
  localparam logic [31:0] Word4Mask = 32'hf800_0000;
  localparam logic [31:0] Word4Val  = 32'hf000_0000;
  localparam logic [31:0] Word3Mask = 32'h00f0_0000;
  localparam logic [31:0] Word3Val  = 32'h00e0_0000;
  localparam logic [31:0] Word2Mask = 32'h0000_e000;
  localparam logic [31:0] Word2Val  = 32'h0000_c000;

  localparam logic [31:0] Lead4Bits = 32'h0700_0000;
  localparam logic [31:0] Lead3Bits = 32'h000f_0000;
  localparam logic [31:0] Lead2Bits = 32'h0000_1f00;
  localparam logic [31:0] ContBits2 = 32'h003f_0000;
  localparam logic [31:0] ContBits1 = 32'h0000_3f00;
  localparam logic [31:0] ContBits0 = 32'h0000_003f;

  // Continuation bytes still expected after a lead byte (0 for one-byte forms and for bytes that lead no sequence)
  function automatic logic [1:0] lead_follow(input logic [7:0] b);
    logic [1:0] n;
    n = 2'd0;
    if ((b & LeadAsciiMask) == 8'h00) begin
      n = 2'd0;
    end else if ((b & Lead2Mask) == Lead2Val) begin
      n = 2'd1;
    end else if ((b & Lead3Mask) == Lead3Val) begin
      n = 2'd2;
    end else if ((b & Lead4Mask) == Lead4Val) begin
      n = 2'd3;
    end
    return n;
  endfunction

  function automatic logic [31:0] decode_word(input logic [31:0] w);
    logic [31:0] v;
    if ((w & Word4Mask) == Word4Val) begin
      v = ((w & Lead4Bits) >> 6) | ((w & ContBits2) >> 4) |
          ((w & ContBits1) >> 2) | (w & ContBits0);
    end else if ((w & Word3Mask) == Word3Val) begin
      v = ((w & Lead3Bits) >> 4) | ((w & ContBits1) >> 2) | (w & ContBits0);
    end else if ((w & Word2Mask) == Word2Val) begin
      v = ((w & Lead2Bits) >> 2) | (w & ContBits0);
    end else begin
      v = w;
    end
    return v;
  endfunction

endpackage

### rtl/utf8sd_byte_if.sv
// Byte channel into the UTF-8 stream decoder: valid/ready with one byte
// and its end-of-string flag per beat. No dependencies.
`timescale 1ns / 1ps

interface utf8sd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       string_end;

  modport source (output valid, data_byte, string_end, input ready);
  modport sink   (input valid, data_byte, string_end, output ready);
endinterface

### rtl/utf8sd_char_if.sv
// Result channel out of the UTF-8 stream decoder: valid/ready with one
// code point and its flags per beat. No dependencies.
`timescale 1ns / 1ps

interface utf8sd_char_if;
  logic        valid;
  logic        ready;
  logic [23:0] char_val;
  logic        has_char;
  logic        end_of_text;

  modport source (output valid, char_val, has_char, end_of_text, input ready);
  modport sink   (input valid, char_val, has_char, end_of_text, output ready);
endinterface

### rtl/utf8_stream_decoder.sv
// UTF-8 stream decoder: one byte per beat in, at most one code point out.
// Input register, then result register; a held byte moves on when the result
// register is free or drains. Throughput: one byte per cycle unless the result
// stalls, set by the combinational decode between the two registers. A stalled
// result blocks input only once the input register is also full. Reset clears
// all valids and the sequence state (packed word, pending count, discard flag).
`timescale 1ns / 1ps
`include "utf8_stream_decoder_defines.svh"

module utf8_stream_decoder
  import utf8sd_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  utf8sd_byte_if.sink   byte_i,
  utf8sd_char_if.source char_o
);

  beat_t   in_beat;
  beat_t   beat;
  logic    beat_vld;
  logic    adv;
  logic    res_vld;
  result_t res;

  assign in_beat = '{data_byte: byte_i.data_byte, string_end: byte_i.string_end};

  utf8sd_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_vld_i   (byte_i.valid),
    .in_beat_i  (in_beat),
    .in_rdy_o   (byte_i.ready),
    .beat_vld_o (beat_vld),
    .beat_o     (beat),
    .adv_i      (adv)
  );

  utf8sd_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .beat_vld_i (beat_vld),
    .beat_i     (beat),
    .adv_o      (adv),
    .res_vld_o  (res_vld),
    .res_o      (res),
    .res_rdy_i  (char_o.ready)
  );

  assign char_o.valid       = res_vld;
  assign char_o.char_val    = res.char_val;
  assign char_o.has_char    = res.has_char;
  assign char_o.end_of_text = res.end_of_text;

  `UTF8SD_ASSERT(a_marker_form,
    !(char_o.valid && !char_o.has_char) || (char_o.end_of_text && char_o.char_val == 24'd0),
    "end marker must be zero and end the text")
  `UTF8SD_ASSERT(a_char_nonzero,
    !(char_o.valid && char_o.has_char) || (char_o.char_val != 24'd0),
    "character result carries zero")
  `UTF8SD_ASSERT(a_full_blocks,
    !(beat_vld && char_o.valid && !char_o.ready) || !byte_i.ready,
    "input taken while both stages are stalled")
  `UTF8SD_ASSERT_NEXT(a_result_holds, char_o.valid && !char_o.ready,
    char_o.valid && $stable(res), "stalled result changed")

endmodule

### rtl/utf8sd_in_stage.sv
// Input register of the UTF-8 stream decoder: holds one accepted beat
// until the sequencer consumes it. Depends on utf8sd_pkg.
`timescale 1ns / 1ps

module utf8sd_in_stage
  import utf8sd_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_vld_i,
  input  beat_t in_beat_i,
  output logic  in_rdy_o,
  output logic  beat_vld_o,
  output beat_t beat_o,
  input  logic  adv_i
);

  logic  vld_q, vld_d;
  beat_t beat_q;

  // Take a new beat whenever the held one is empty or leaves this cycle
  assign in_rdy_o = !vld_q || adv_i;

  always_comb begin
    vld_d = vld_q;
    if (in_rdy_o) begin
      vld_d = in_vld_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_rdy_o && in_vld_i) begin
      beat_q <= in_beat_i;
    end
  end

  assign beat_vld_o = vld_q;
  assign beat_o     = beat_q;

endmodule

### rtl/utf8sd_seq.sv
// Sequence state, word packing, decode and result register of the UTF-8
// stream decoder. Depends on utf8sd_pkg.
`timescale 1ns / 1ps

module utf8sd_seq
  import utf8sd_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    beat_vld_i,
  input  beat_t   beat_i,
  output logic    adv_o,
  output logic    res_vld_o,
  output result_t res_o,
  input  logic    res_rdy_i
);

  logic [31:0] word_q, word_d;
  logic [1:0]  left_q, left_d;
  logic        disc_q, disc_d;
  logic        res_vld_q, res_vld_d;
  result_t     res_q, res_d;

  logic        emit;
  logic [31:0] value;

  // Consume the held beat when the result register is free or drains now
  assign adv_o = beat_vld_i && (!res_vld_q || res_rdy_i);

  always_comb begin
    word_d = word_q;
    left_d = left_q;
    disc_d = disc_q;
    emit   = 1'b0;
    value  = 32'd0;
    res_d  = res_q;

    if (disc_q) begin
      if (beat_i.string_end) begin
        disc_d = 1'b0;
        word_d = 32'd0;
        left_d = 2'd0;
      end
    end else if (left_q == 2'd0) begin
      word_d = {24'd0, beat_i.data_byte};
      left_d = lead_follow(beat_i.data_byte);
      emit   = (left_d == 2'd0) || beat_i.string_end;
    end else begin
      word_d = {word_q[23:0], beat_i.data_byte};
      left_d = left_q - 2'd1;
      emit   = (left_d == 2'd0) || beat_i.string_end;
    end

    if (emit) begin
      value  = decode_word(word_d);
      word_d = 32'd0;
      left_d = 2'd0;
      if (value == 32'd0) begin
        res_d  = '{char_val: 24'd0, has_char: 1'b0, end_of_text: 1'b1};
        disc_d = !beat_i.string_end;
      end else begin
        res_d = '{char_val: value[23:0], has_char: 1'b1,
                  end_of_text: beat_i.string_end};
      end
    end
  end

  always_comb begin
    res_vld_d = res_vld_q && !res_rdy_i;
    if (adv_o) begin
      res_vld_d = emit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_q    <= 32'd0;
      left_q    <= 2'd0;
      disc_q    <= 1'b0;
      res_vld_q <= 1'b0;
    end else begin
      res_vld_q <= res_vld_d;
      if (adv_o) begin
        word_q <= word_d;
        left_q <= left_d;
        disc_q <= disc_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_o && emit) begin
      res_q <= res_d;
    end
  end

  assign res_vld_o = res_vld_q;
  assign res_o     = res_q;

endmodule
